// ===== design/sdspi_pkg.sv =====
// ---------------------------------------------------------------------------
// sdspi_pkg: shared types and constants for the SD SPI command unit
// Beat layouts, config register indexes, status codes, phase codes and the
// byte-wide CRC7 update.
// ---------------------------------------------------------------------------
package sdspi_pkg;

  localparam int MAX_PAYLOAD_DEF = 512;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 24;

  // config register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_RESP_TIMEOUT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_READY_TIMEOUT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_ADDR    = 2'd2;

  localparam logic [15:0] RESP_TIMEOUT_RST  = 16'd300;
  localparam logic [23:0] READY_TIMEOUT_RST = 24'd37500;

  // beat kind on the input side
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_XFER  = 1'b1;

  // completion status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_R1    = 2'd1;
  localparam logic [1:0] ST_NO_TOKEN = 2'd2;

  localparam logic [7:0] BYTE_IDLE   = 8'hFF;
  localparam logic [7:0] BYTE_TOKEN  = 8'hFE;
  localparam logic [1:0] CMD_PREFIX  = 2'b01;
  localparam logic [6:0] CRC7_POLY   = 7'h09;

  typedef enum logic [8:0] {
    PH_IDLE  = 9'b000000001,
    PH_PRE   = 9'b000000010,
    PH_SEL   = 9'b000000100,
    PH_SEND  = 9'b000001000,
    PH_R1    = 9'b000010000,
    PH_TOKEN = 9'b000100000,
    PH_DATA  = 9'b001000000,
    PH_CRC   = 9'b010000000,
    PH_READY = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic        is_block_cmd;
    logic        want_response;
    logic        framed_data;
    logic        wait_ready;
    logic [9:0]  payload_len;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_request;
    logic       chip_select_n;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       data_last;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] r1;
  } res_t;

  typedef struct packed {
    logic [15:0] response_timeout;
    logic [23:0] ready_timeout;
    logic        block_addressing;
  } cfg_t;

  // CRC7 advanced by one byte, MSB first
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] b);
    logic [6:0] c;
    logic       fb;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb = b[i] ^ c[6];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ CRC7_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/sd_spi_command_transaction_unit.sv =====
// ---------------------------------------------------------------------------
// sd_spi_command_transaction_unit: SD card SPI-mode command engine
// Sequences one SD command per transaction over a byte-wide exchange port.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per event. tuser = 0 starts a transaction (command,
//           argument, flags in tdata); tuser = 1 reports the byte the card
//           returned in the exchange just finished (rx_byte).
//   out_* : exactly one beat per input beat: the next byte to exchange, its
//           chip select level, any payload byte (tuser[0], tlast on the last
//           one) and the completion flag with status and R1 (tuser[1]).
//   cfg_* : register writes, taken at any edge with cfg_we high; write only
//           while no transaction beat is outstanding.
// Each output beat is registered and appears in the cycle after its input beat
// is accepted; one beat per cycle is sustained while out_tready is high,
// limited only by the single output register. When out_tready is low the result
// holds, and one more beat is accepted only while the output register is empty.
// Reset returns the sequencer to idle and the config registers to their defaults.
// ---------------------------------------------------------------------------
module sd_spi_command_transaction_unit #(
  parameter int MAX_PAYLOAD = sdspi_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tdata: cmd_index[5:0], cmd_arg[37:6], is_block_cmd[38], want_response[39],
  //        framed_data[40], wait_ready[41], payload_len[51:42], rx_byte[59:52]
  input  logic [sdspi_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: cmd
  input  logic                                 in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata: tx_byte[7:0], tx_request[8], chip_select_n[9], data_byte[17:10],
  //        status[19:18], r1[27:20]
  output logic [sdspi_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // tuser: data_valid[0], done_res[1]
  output logic [1:0]                           out_tuser,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [sdspi_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sdspi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  sdspi_pkg::cfg_t  cfg_r;
  sdspi_pkg::item_t item;
  sdspi_pkg::res_t  res, res_r;
  logic             accept;
  logic             out_valid_r;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign item.cmd           = in_tuser;
  assign item.cmd_index     = in_tdata[5:0];
  assign item.cmd_arg       = in_tdata[37:6];
  assign item.is_block_cmd  = in_tdata[38];
  assign item.want_response = in_tdata[39];
  assign item.framed_data   = in_tdata[40];
  assign item.wait_ready    = in_tdata[41];
  assign item.payload_len   = in_tdata[51:42];
  assign item.rx_byte       = in_tdata[59:52];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.response_timeout <= sdspi_pkg::RESP_TIMEOUT_RST;
      cfg_r.ready_timeout    <= sdspi_pkg::READY_TIMEOUT_RST;
      cfg_r.block_addressing <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sdspi_pkg::REG_RESP_TIMEOUT:  cfg_r.response_timeout <= cfg_wdata[15:0];
        sdspi_pkg::REG_READY_TIMEOUT: cfg_r.ready_timeout    <= cfg_wdata;
        sdspi_pkg::REG_BLOCK_ADDR:    cfg_r.block_addressing <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  sdspi_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (item),
    .cfg    (cfg_r),
    .res    (res)
  );

  // output register: loads on every accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r.r1, res_r.status, res_r.data_byte,
                       res_r.chip_select_n, res_r.tx_request, res_r.tx_byte};
  assign out_tuser  = {res_r.done_res, res_r.data_valid};
  assign out_tlast  = res_r.data_last;

endmodule

// ===== design/sdspi_core.sv =====
// ---------------------------------------------------------------------------
// sdspi_core: command sequencer for the SD SPI command unit
// Holds the transaction state and works out the result of each beat.
// ---------------------------------------------------------------------------
module sdspi_core #(
  parameter int MAX_PAYLOAD = sdspi_pkg::MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  sdspi_pkg::item_t   item,
  input  sdspi_pkg::cfg_t    cfg,
  output sdspi_pkg::res_t    res
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int CMP_W = (LEN_W > 10) ? LEN_W : 10;

  sdspi_pkg::phase_t phase_r, phase_nxt;
  logic [39:0]      shift_r, shift_nxt;
  logic [6:0]       crc_r, crc_nxt;
  logic [LEN_W-1:0] bc_r, bc_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [23:0]      poll_r, poll_nxt;
  logic [7:0]       r1_r, r1_nxt;
  logic             want_r, want_nxt;
  logic             data_r, data_nxt;
  logic             wait_r, wait_nxt;

  logic [23:0]      rto, yto;
  logic [LEN_W-1:0] bc_inc;
  logic [CMP_W-1:0] len_ext;
  logic [31:0]      arg_scaled;
  logic [7:0]       cmd_byte0;
  logic [7:0]       send_byte;
  sdspi_pkg::phase_t ap_tgt, pl_tgt, tgt;
  logic             do_enter;
  logic [1:0]       rel_st;

  // a zero timeout behaves as a single poll
  assign rto = (cfg.response_timeout == 16'd0) ? 24'd1 : {8'd0, cfg.response_timeout};
  assign yto = (cfg.ready_timeout == 24'd0) ? 24'd1 : cfg.ready_timeout;

  assign bc_inc     = bc_r + LEN_W'(1);
  assign len_ext    = CMP_W'(item.payload_len);
  assign arg_scaled = (item.is_block_cmd && !cfg.block_addressing) ?
                      {item.cmd_arg[22:0], 9'd0} : item.cmd_arg;
  assign cmd_byte0  = {sdspi_pkg::CMD_PREFIX, item.cmd_index};

  // where to go once the payload is done, and where a payload starts
  assign ap_tgt = data_r ? sdspi_pkg::PH_CRC : (wait_r ? sdspi_pkg::PH_READY : sdspi_pkg::PH_IDLE);
  assign pl_tgt = (len_r != '0) ? sdspi_pkg::PH_DATA : ap_tgt;

  always_comb begin
    case (bc_r[2:0])
      3'd1:    send_byte = shift_r[31:24];
      3'd2:    send_byte = shift_r[23:16];
      3'd3:    send_byte = shift_r[15:8];
      3'd4:    send_byte = shift_r[7:0];
      default: send_byte = shift_r[39:32];
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    crc_nxt   = crc_r;
    bc_nxt    = bc_r;
    len_nxt   = len_r;
    poll_nxt  = poll_r;
    r1_nxt    = r1_r;
    want_nxt  = want_r;
    data_nxt  = data_r;
    wait_nxt  = wait_r;
    tgt       = sdspi_pkg::PH_IDLE;
    do_enter  = 1'b0;
    rel_st    = sdspi_pkg::ST_OK;

    res               = '0;
    res.tx_byte       = sdspi_pkg::BYTE_IDLE;
    res.chip_select_n = 1'b1;

    if (accept) begin
      if (item.cmd == sdspi_pkg::CMD_START) begin
        want_nxt  = item.want_response;
        data_nxt  = item.framed_data | item.is_block_cmd;
        wait_nxt  = item.wait_ready | item.is_block_cmd;
        len_nxt   = (len_ext > CMP_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : LEN_W'(len_ext);
        shift_nxt = {cmd_byte0, arg_scaled};
        // CRC is built one byte per beat as the command goes out
        crc_nxt   = sdspi_pkg::crc7_byte(7'd0, cmd_byte0);
        r1_nxt    = sdspi_pkg::BYTE_IDLE;
        bc_nxt    = '0;
        poll_nxt  = 24'd0;
        res.tx_request = 1'b1;
        phase_nxt = sdspi_pkg::PH_PRE;
      end else begin
        unique case (phase_r)
          sdspi_pkg::PH_PRE: begin
            res.tx_request    = 1'b1;
            res.chip_select_n = 1'b0;
            phase_nxt         = sdspi_pkg::PH_SEL;
          end
          sdspi_pkg::PH_SEL: begin
            res.tx_byte       = shift_r[39:32];
            res.tx_request    = 1'b1;
            res.chip_select_n = 1'b0;
            bc_nxt            = LEN_W'(1);
            phase_nxt         = sdspi_pkg::PH_SEND;
          end
          sdspi_pkg::PH_SEND: begin
            if (bc_r <= LEN_W'(4)) begin
              res.tx_byte       = send_byte;
              res.tx_request    = 1'b1;
              res.chip_select_n = 1'b0;
              crc_nxt           = sdspi_pkg::crc7_byte(crc_r, send_byte);
              bc_nxt            = bc_inc;
            end else if (bc_r == LEN_W'(5)) begin
              res.tx_byte       = {crc_r, 1'b1};
              res.tx_request    = 1'b1;
              res.chip_select_n = 1'b0;
              bc_nxt            = bc_inc;
            end else begin
              do_enter = 1'b1;
              tgt      = sdspi_pkg::PH_R1;
            end
          end
          sdspi_pkg::PH_R1: begin
            r1_nxt = item.rx_byte;
            if (!item.rx_byte[7]) begin
              do_enter = 1'b1;
              if (want_r) begin
                tgt = data_r ? sdspi_pkg::PH_TOKEN : pl_tgt;
              end else begin
                tgt = wait_r ? sdspi_pkg::PH_READY : sdspi_pkg::PH_IDLE;
              end
            end else if (poll_r < rto) begin
              res.tx_request    = 1'b1;
              res.chip_select_n = 1'b0;
              poll_nxt          = poll_r + 24'd1;
            end else begin
              do_enter = 1'b1;
              rel_st   = sdspi_pkg::ST_NO_R1;
            end
          end
          sdspi_pkg::PH_TOKEN: begin
            if (item.rx_byte == sdspi_pkg::BYTE_TOKEN) begin
              do_enter = 1'b1;
              tgt      = pl_tgt;
            end else if (poll_r < rto) begin
              res.tx_request    = 1'b1;
              res.chip_select_n = 1'b0;
              poll_nxt          = poll_r + 24'd1;
            end else begin
              do_enter = 1'b1;
              rel_st   = sdspi_pkg::ST_NO_TOKEN;
            end
          end
          sdspi_pkg::PH_DATA: begin
            bc_nxt         = bc_inc;
            res.data_byte  = item.rx_byte;
            res.data_valid = 1'b1;
            if (bc_inc >= len_r) begin
              res.data_last = 1'b1;
              do_enter      = 1'b1;
              tgt           = ap_tgt;
            end else begin
              res.tx_request    = 1'b1;
              res.chip_select_n = 1'b0;
            end
          end
          sdspi_pkg::PH_CRC: begin
            bc_nxt = bc_inc;
            if (bc_inc < LEN_W'(2)) begin
              res.tx_request    = 1'b1;
              res.chip_select_n = 1'b0;
            end else begin
              do_enter = 1'b1;
              tgt      = wait_r ? sdspi_pkg::PH_READY : sdspi_pkg::PH_IDLE;
            end
          end
          sdspi_pkg::PH_READY: begin
            if (item.rx_byte == sdspi_pkg::BYTE_IDLE || poll_r >= yto) begin
              do_enter = 1'b1;
            end else begin
              res.tx_request    = 1'b1;
              res.chip_select_n = 1'b0;
              poll_nxt          = poll_r + 24'd1;
            end
          end
          default: begin
            phase_nxt = sdspi_pkg::PH_IDLE;
          end
        endcase

        // common entry into the next phase, or release of chip select
        if (do_enter) begin
          phase_nxt = tgt;
          if (tgt == sdspi_pkg::PH_IDLE) begin
            res.done_res = 1'b1;
            res.status   = rel_st;
            res.r1       = r1_nxt;
          end else begin
            res.tx_request    = 1'b1;
            res.chip_select_n = 1'b0;
            if (tgt == sdspi_pkg::PH_DATA || tgt == sdspi_pkg::PH_CRC) begin
              bc_nxt = '0;
            end else begin
              poll_nxt = 24'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sdspi_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    crc_r   <= crc_nxt;
    bc_r    <= bc_nxt;
    len_r   <= len_nxt;
    poll_r  <= poll_nxt;
    r1_r    <= r1_nxt;
    want_r  <= want_nxt;
    data_r  <= data_nxt;
    wait_r  <= wait_nxt;
  end

endmodule
